// File: rtl/core/frq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frq_pkg - shared types and constants for the quarter-turn frame rotator
// Field widths, register indexes, opcodes, rotation modes and status codes.
// ----------------------------------------------------------------------------
package frq_pkg;

  // Payload and register widths
  localparam int PIX_W     = 32;
  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 2;

  // Largest value a dimension register can hold
  localparam int DIM_MAX = (1 << DIM_W) - 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_MODE = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd64;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd64;

  // Request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_DIMS   = 2'd1,
    ST_NOT_LOADED = 2'd2
  } status_t;

endpackage

// File: rtl/core/frame_rotate_quarter_turns_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rotate_quarter_turns_top - quarter-turn rotator for BGRA frames
// Write requests scatter source pixels into a frame store at their rotated
// place; read requests drain the store in output raster order.
// ----------------------------------------------------------------------------
// The block takes one request in every clock cycle: busy is always low. A
// request that gives a result (any read, or any request while the frame size
// is invalid) shows it on the out_ ports, strobed by out_valid, once it has
// passed the input register stage and then the result register stage, which
// for a read is the registered read of the single-port frame store; a
// successful or ignored write gives none. A write forms its rotated store
// address from the input register stage with one multiply. The receiver
// cannot hold a result off: it must take it in the one cycle that out_valid
// is high. The store needs no clearing pass after reset, so requests may
// follow reset at once. Configuration writes restart the frame and are to
// be made only while no result is still on its way.
module frame_rotate_quarter_turns_top #(
  parameter int MAX_PIXELS = 4096,
  parameter int MAX_SIDE   = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_opcode,
  input  logic [frq_pkg::PIX_W-1:0]      in_pixel_in,
  // result channel
  output logic                           out_valid,
  output logic [frq_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                           out_last_pixel,
  output logic [1:0]                     out_status,
  // configuration port
  input  logic                           cfg_wr_en,
  input  logic [frq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frq_pkg::DIM_W-1:0]      cfg_wr_data
);

  localparam int DIM_W    = frq_pkg::DIM_W;
  localparam int PIX_W    = frq_pkg::PIX_W;
  localparam int DPW      = 2 * DIM_W;
  localparam int AW       = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int PW       = $clog2(MAX_PIXELS + 1);
  localparam int SIDE_CAP = (MAX_SIDE < frq_pkg::DIM_MAX) ? MAX_SIDE : frq_pkg::DIM_MAX;
  localparam int XW       = (SIDE_CAP > 1) ? $clog2(SIDE_CAP) : 1;
  localparam int PRW      = XW + DIM_W;

  // Configuration registers
  logic [DIM_W-1:0]    width_r;
  logic [DIM_W-1:0]    height_r;
  frq_pkg::rot_mode_t  rot_r;

  // Frame position state
  logic [XW-1:0]       col_r,    col_nxt;
  logic [XW-1:0]       row_r,    row_nxt;
  logic [AW-1:0]       drain_r,  drain_nxt;
  logic                loaded_r, loaded_nxt;

  // Input stage
  logic                s1_vld_r, s1_vld_nxt;
  logic                s1_wr_r,  s1_wr_nxt;
  logic                s1_rd_r,  s1_rd_nxt;
  frq_pkg::status_t    s1_status_r, s1_status_nxt;
  logic                s1_last_r, s1_last_nxt;
  logic [XW-1:0]       s1_tx_r,  s1_tx_nxt;
  logic [XW-1:0]       s1_ty_r,  s1_ty_nxt;
  logic [DIM_W-1:0]    s1_ow_r,  s1_ow_nxt;
  logic [PIX_W-1:0]    s1_pix_r;
  logic [AW-1:0]       s1_idx_r;

  // Result stage
  logic                out_vld_r;
  frq_pkg::status_t    out_status_r;
  logic                out_last_r;
  logic [PIX_W-1:0]    rd_data_r;

  // Frame store
  logic [PIX_W-1:0]    mem [MAX_PIXELS];

  logic                acc;
  logic                cfg_hit;
  logic [DPW-1:0]      dim_prod;
  logic                dims_ok;
  logic                last_rd;
  logic [DIM_W-1:0]    x_ext;
  logic [DIM_W-1:0]    y_ext;
  logic [PRW-1:0]      wr_prod;
  logic [AW-1:0]       wr_addr;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign cfg_hit = cfg_wr_en && (cfg_index == frq_pkg::CFG_FRAME_WIDTH ||
                                 cfg_index == frq_pkg::CFG_FRAME_HEIGHT ||
                                 cfg_index == frq_pkg::CFG_ROTATION_MODE);

  // Check the frame size against the side and pixel caps
  assign dim_prod = width_r * height_r;
  assign dims_ok  = (width_r != '0) && (height_r != '0) &&
                    (32'(width_r) <= 32'(MAX_SIDE)) &&
                    (32'(height_r) <= 32'(MAX_SIDE)) &&
                    (dim_prod <= DPW'(MAX_PIXELS));

  assign x_ext   = DIM_W'(col_r);
  assign y_ext   = DIM_W'(row_r);
  assign last_rd = (PW'(drain_r) + PW'(1)) >= PW'(dim_prod);

  // Decode the request, advance the frame position, form the rotated place
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    drain_nxt     = drain_r;
    loaded_nxt    = loaded_r;
    s1_vld_nxt    = 1'b0;
    s1_wr_nxt     = 1'b0;
    s1_rd_nxt     = 1'b0;
    s1_status_nxt = frq_pkg::ST_OK;
    s1_last_nxt   = 1'b0;
    s1_tx_nxt     = col_r;
    s1_ty_nxt     = row_r;
    s1_ow_nxt     = width_r;

    case (rot_r)
      frq_pkg::ROT_90: begin
        s1_tx_nxt = XW'(height_r - DIM_W'(1) - y_ext);
        s1_ty_nxt = col_r;
        s1_ow_nxt = height_r;
      end
      frq_pkg::ROT_180: begin
        s1_tx_nxt = XW'(width_r - DIM_W'(1) - x_ext);
        s1_ty_nxt = XW'(height_r - DIM_W'(1) - y_ext);
      end
      frq_pkg::ROT_270: begin
        s1_tx_nxt = row_r;
        s1_ty_nxt = XW'(width_r - DIM_W'(1) - x_ext);
        s1_ow_nxt = height_r;
      end
      default: begin
      end
    endcase

    if (acc) begin
      if (!dims_ok) begin
        s1_vld_nxt    = 1'b1;
        s1_status_nxt = frq_pkg::ST_BAD_DIMS;
      end else if (in_opcode == frq_pkg::OP_WRITE) begin
        if (!loaded_r) begin
          s1_wr_nxt = 1'b1;
          if ((x_ext + DIM_W'(1)) >= width_r) begin
            col_nxt = '0;
            if ((y_ext + DIM_W'(1)) >= height_r) begin
              row_nxt    = '0;
              loaded_nxt = 1'b1;
            end else begin
              row_nxt = XW'(y_ext + DIM_W'(1));
            end
          end else begin
            col_nxt = XW'(x_ext + DIM_W'(1));
          end
        end
      end else if (!loaded_r) begin
        s1_vld_nxt    = 1'b1;
        s1_status_nxt = frq_pkg::ST_NOT_LOADED;
      end else begin
        s1_vld_nxt  = 1'b1;
        s1_rd_nxt   = 1'b1;
        s1_last_nxt = last_rd;
        if (last_rd) begin
          col_nxt    = '0;
          row_nxt    = '0;
          drain_nxt  = '0;
          loaded_nxt = 1'b0;
        end else begin
          drain_nxt = drain_r + AW'(1);
        end
      end
    end

    // Restart the frame on any known register write
    if (cfg_hit) begin
      col_nxt    = '0;
      row_nxt    = '0;
      drain_nxt  = '0;
      loaded_nxt = 1'b0;
    end
  end

  // Hold configuration, frame position and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= frq_pkg::FRAME_WIDTH_RST;
      height_r     <= frq_pkg::FRAME_HEIGHT_RST;
      rot_r        <= frq_pkg::ROT_0;
      col_r        <= '0;
      row_r        <= '0;
      drain_r      <= '0;
      loaded_r     <= 1'b0;
      s1_vld_r     <= 1'b0;
      s1_wr_r      <= 1'b0;
      s1_rd_r      <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == frq_pkg::CFG_FRAME_WIDTH) begin
        width_r <= cfg_wr_data;
      end
      if (cfg_wr_en && cfg_index == frq_pkg::CFG_FRAME_HEIGHT) begin
        height_r <= cfg_wr_data;
      end
      if (cfg_wr_en && cfg_index == frq_pkg::CFG_ROTATION_MODE) begin
        rot_r <= frq_pkg::rot_mode_t'(cfg_wr_data[1:0]);
      end
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      drain_r   <= drain_nxt;
      loaded_r  <= loaded_nxt;
      s1_vld_r  <= s1_vld_nxt;
      s1_wr_r   <= s1_wr_nxt;
      s1_rd_r   <= s1_rd_nxt;
      out_vld_r <= s1_vld_r;
    end
  end

  // Capture request payload and result fields
  always_ff @(posedge clk) begin
    s1_status_r  <= s1_status_nxt;
    s1_last_r    <= s1_last_nxt;
    s1_tx_r      <= s1_tx_nxt;
    s1_ty_r      <= s1_ty_nxt;
    s1_ow_r      <= s1_ow_nxt;
    s1_pix_r     <= in_pixel_in;
    s1_idx_r     <= drain_r;
    out_status_r <= s1_status_r;
    out_last_r   <= s1_last_r;
  end

  // Rotated store address: row times output width plus column
  assign wr_prod = s1_ty_r * s1_ow_r;
  assign wr_addr = AW'(wr_prod + PRW'(s1_tx_r));

  // Scatter writes and drain reads on the single store port
  always_ff @(posedge clk) begin
    if (s1_wr_r) begin
      mem[wr_addr] <= s1_pix_r;
    end
    if (s1_rd_r) begin
      rd_data_r <= mem[s1_idx_r];
    end
  end

  // Drive the result; error results carry a zero pixel
  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_last_pixel = out_last_r;
  assign out_pixel_out  = (out_status_r == frq_pkg::ST_OK) ? rd_data_r : '0;

  // A write request never yields a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_wr_r |-> !s1_vld_r)
    else $error("write request produced a result");

  // The last-pixel flag only rides on a good result
  a_last_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_pixel |-> (out_valid && out_status == frq_pkg::ST_OK))
    else $error("last pixel flagged on an error or idle cycle");

  // A good result comes from a read taken while the frame was loaded
  a_ok_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == frq_pkg::ST_OK) |-> $past(loaded_r, 2))
    else $error("pixel drained from an incomplete frame");

  // Draining the last pixel restarts the frame
  a_drain_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_rd_nxt && s1_last_nxt) |=> (!loaded_r && drain_r == '0 &&
                                    col_r == '0 && row_r == '0))
    else $error("frame not restarted after last pixel");

  // Write and read never share the store port in one cycle
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_wr_r && s1_rd_r))
    else $error("store port asked to write and read together");

endmodule
